[rtl/buffer_slot_pool_with_access_check_macros.svh]
// assertion macros shared by the slot pool checker
`ifndef BUFFER_SLOT_POOL_WITH_ACCESS_CHECK_MACROS_SVH
`define BUFFER_SLOT_POOL_WITH_ACCESS_CHECK_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSPOOL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSPOOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bspool_pkg.sv]
// shared types and constants of the buffer slot pool
`timescale 1ns / 1ps

package bspool_pkg;

  // pool geometry
  localparam int unsigned POOL_DEPTH  = 8;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned BLOCK_SHIFT = 12;
  localparam int unsigned BLK_W       = 32;
  localparam int unsigned BUF_OFF_W   = 15;
  localparam int unsigned BYTE_OFF_W  = 44;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 4;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  // configuration register indexes
  localparam logic CFG_POOL_COUNT  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN    = 3'd0,
    CMD_ACQUIRE = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_ACCESS  = 3'd3,
    CMD_CLOSE   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 4'd0,
    ST_ALREADY_OPEN = 4'd1,
    ST_BAD_POOL     = 4'd2,
    ST_NOT_OPEN     = 4'd3,
    ST_EXHAUSTED    = 4'd4,
    ST_BAD_SLOT     = 4'd5,
    ST_NO_SPACE     = 4'd6,
    ST_DOUBLE       = 4'd7,
    ST_OUTSTANDING  = 4'd8,
    ST_TOO_SMALL    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } stack_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN
  } fsm_e;

  // one stack entry as handed between neighbor cells
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } ent_t;

  // search token that walks down the chain
  typedef struct packed {
    logic tok;
    logic hit;
  } scan_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    stack_op_e         op;
    logic [CNT_W-1:0]  pool;
    logic [SLOT_W-1:0] slot;
  } cell_ctl_t;

endpackage

[rtl/bspool_cell.sv]
// one cell of the free stack chain: an entry plus one stage of the search
`timescale 1ns / 1ps

module bspool_cell import bspool_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [SLOT_W-1:0] idx_i,
  input  ent_t              lower_i,  // neighbor nearer the top of stack
  input  ent_t              upper_i,  // neighbor nearer the bottom of stack
  input  scan_t             scan_i,
  output ent_t              ent_o,
  output scan_t             scan_o
);

  logic              valid_q, valid_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  scan_t             scan_q, scan_d;

  // entry update: load, clear, shift toward bottom on push, toward top on pop
  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    case (ctl_i.op)
      OP_LOAD: begin
        valid_d = ({1'b0, idx_i} < ctl_i.pool);
        slot_d  = idx_i;
      end
      OP_PUSH: begin
        valid_d = lower_i.valid;
        slot_d  = lower_i.slot;
      end
      OP_POP: begin
        valid_d = upper_i.valid;
        slot_d  = upper_i.slot;
      end
      OP_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  // search stage: or in a match against this entry as the token passes
  always_comb begin
    scan_d.tok = scan_i.tok;
    scan_d.hit = scan_i.tok & (scan_i.hit | (valid_q & (slot_q == ctl_i.slot)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      valid_q <= valid_d;
      scan_q  <= scan_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign ent_o.valid = valid_q;
  assign ent_o.slot  = slot_q;
  assign scan_o      = scan_q;

endmodule

[rtl/buffer_slot_pool_with_access_check.sv]
// top level of the buffer slot pool with access check
//
// Commands enter on the s_axis channel (open, acquire, release, access check,
// close) and each produces exactly one response on the m_axis channel.
// Pool size and device block count are set on the cfg write port, which the
// user must write only while idle; the block does not enforce this. Open
// latches them. The free stack is a row of POOL_DEPTH cells, cell 0 holding
// the top; push and pop shift every cell by one place together. A command
// goes from accept to the EXEC state, which writes its response to the
// output register; a release of a valid slot on an open pool first sends a
// search token down the cell chain, one cell a cycle, in the SCAN state.
// One command is in flight at a time; the next is accepted once the response
// is written to the output register, so a new command can be taken while
// that response waits. If the receiver stalls, a finished command waits
// in the sequencer until the output register frees, with s_axis_tready_o low.
// Reset closes the pool, clears the outstanding count and the terminal flag,
// empties the stack and the output register, and restores the cfg defaults
// (pool count 8, block count 0). No clearing pass is needed.
`timescale 1ns / 1ps

module buffer_slot_pool_with_access_check import bspool_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cfg write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [BLK_W-1:0]      cfg_data_i,
  // command stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // cmd[2:0], slot[5:3], block_id[37:6]
  // response stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // status[3:0], slot_out[6:4],
                                                 // buffer_offset[21:7],
                                                 // byte_offset[65:22],
                                                 // outstanding[69:66]
);

  fsm_e                  state_q, state_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [BLK_W-1:0]      blk_q;
  logic [CNT_W-1:0]      pool_cfg_q;
  logic [BLK_W-1:0]      blocks_cfg_q;
  logic [CNT_W-1:0]      pool_lat_q, pool_lat_d;
  logic [BLK_W-1:0]      blk_lat_q, blk_lat_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic                  open_q, open_d;
  logic                  term_q, term_d;
  logic                  scan_done_q, scan_done_d;
  logic                  hit_q, hit_d;
  logic                  m_valid_q, m_valid_d;
  logic [STATUS_W-1:0]   r_status_q, r_status_d;
  logic [SLOT_W-1:0]     r_slot_q, r_slot_d;
  logic [BUF_OFF_W-1:0]  r_buf_q, r_buf_d;
  logic [BYTE_OFF_W-1:0] r_byte_q, r_byte_d;
  logic [CNT_W-1:0]      r_cnt_q, r_cnt_d;

  logic                  in_fire;
  logic                  out_free;
  logic                  need_scan;
  logic                  commit;
  stack_op_e             op;
  cell_ctl_t             ctl;
  scan_t                 scan_start;
  ent_t                  push_ent;
  ent_t                  ent   [POOL_DEPTH];
  scan_t                 scan  [POOL_DEPTH];
  logic                  slot_ok;
  logic                  cnt_inc_ok;

  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = (state_q == FSM_IDLE);

  // cfg registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_cfg_q   <= CNT_W'(POOL_DEPTH);
      blocks_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_COUNT:  pool_cfg_q   <= cfg_data_i[CNT_W-1:0];
        CFG_BLOCK_COUNT: blocks_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command holding register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tdata_i[CMD_W-1:0];
      slot_q <= s_axis_tdata_i[CMD_W +: SLOT_W];
      blk_q  <= s_axis_tdata_i[CMD_W+SLOT_W +: BLK_W];
    end
  end

  assign slot_ok    = ({1'b0, slot_q} < pool_lat_q);
  assign cnt_inc_ok = (out_cnt_q != {CNT_W{1'b1}});

  // command decode, status and state updates
  always_comb begin
    r_status_d = ST_OK;
    r_slot_d   = slot_q;
    r_buf_d    = '0;
    r_byte_d   = '0;
    out_cnt_d  = out_cnt_q;
    open_d     = open_q;
    term_d     = term_q;
    pool_lat_d = pool_lat_q;
    blk_lat_d  = blk_lat_q;
    op         = OP_HOLD;
    need_scan  = 1'b0;
    case (cmd_q)
      CMD_OPEN: begin
        if (open_q || term_q) begin
          r_status_d = ST_ALREADY_OPEN;
        end else if (pool_cfg_q == '0 || pool_cfg_q > CNT_W'(POOL_DEPTH)) begin
          r_status_d = ST_BAD_POOL;
        end else if (blocks_cfg_q == '0) begin
          r_status_d = ST_TOO_SMALL;
        end else begin
          pool_lat_d = pool_cfg_q;
          blk_lat_d  = blocks_cfg_q;
          op         = OP_LOAD;
          open_d     = 1'b1;
        end
      end
      CMD_ACQUIRE: begin
        if (!open_q || term_q) begin
          r_status_d = ST_NOT_OPEN;
        end else if (!ent[0].valid) begin
          r_status_d = ST_EXHAUSTED;
        end else begin
          op       = OP_POP;
          r_slot_d = ent[0].slot;
          if (cnt_inc_ok) out_cnt_d = out_cnt_q + 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (term_q) begin
          if (out_cnt_q != '0) out_cnt_d = out_cnt_q - 1'b1;
        end else if (!open_q) begin
          r_status_d = ST_NOT_OPEN;
        end else if (!slot_ok) begin
          r_status_d = ST_BAD_SLOT;
        end else if (!scan_done_q) begin
          need_scan = 1'b1;
        end else begin
          if (hit_q) begin
            r_status_d = ST_DOUBLE;
          end else if (!ent[POOL_DEPTH-1].valid) begin
            op = OP_PUSH;
          end
          if (out_cnt_q != '0) out_cnt_d = out_cnt_q - 1'b1;
        end
      end
      CMD_ACCESS: begin
        if (!open_q || term_q) begin
          r_status_d = ST_NOT_OPEN;
        end else if (!slot_ok) begin
          r_status_d = ST_BAD_SLOT;
        end else if (blk_q >= blk_lat_q) begin
          r_status_d = ST_NO_SPACE;
        end else begin
          r_buf_d  = BUF_OFF_W'(slot_q) << BLOCK_SHIFT;
          r_byte_d = BYTE_OFF_W'(blk_q) << BLOCK_SHIFT;
        end
      end
      CMD_CLOSE: begin
        if (open_q) begin
          if (out_cnt_q != '0) r_status_d = ST_OUTSTANDING;
          term_d = 1'b1;
          open_d = 1'b0;
          op     = OP_CLEAR;
        end
      end
      default: ;
    endcase
    r_cnt_d = out_cnt_d;
  end

  assign commit = (state_q == FSM_EXEC) & ~need_scan & out_free;

  // sequencer
  always_comb begin
    state_d     = state_q;
    scan_done_d = scan_done_q;
    hit_d       = hit_q;
    m_valid_d   = m_valid_q & ~m_axis_tready_i;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (need_scan) begin
          state_d = FSM_SCAN;
        end else if (out_free) begin
          m_valid_d   = 1'b1;
          scan_done_d = 1'b0;
          state_d     = FSM_IDLE;
        end
      end
      FSM_SCAN: begin
        if (scan[POOL_DEPTH-1].tok) begin
          hit_d       = scan[POOL_DEPTH-1].hit;
          scan_done_d = 1'b1;
          state_d     = FSM_EXEC;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      scan_done_q <= 1'b0;
      hit_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      out_cnt_q   <= '0;
      open_q      <= 1'b0;
      term_q      <= 1'b0;
      pool_lat_q  <= '0;
      blk_lat_q   <= '0;
    end else begin
      state_q     <= state_d;
      scan_done_q <= scan_done_d;
      hit_q       <= hit_d;
      m_valid_q   <= m_valid_d;
      if (commit) begin
        out_cnt_q  <= out_cnt_d;
        open_q     <= open_d;
        term_q     <= term_d;
        pool_lat_q <= pool_lat_d;
        blk_lat_q  <= blk_lat_d;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      r_status_q <= r_status_d;
      r_slot_q   <= r_slot_d;
      r_buf_q    <= r_buf_d;
      r_byte_q   <= r_byte_d;
      r_cnt_q    <= r_cnt_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, r_cnt_q, r_byte_q, r_buf_q, r_slot_q, r_status_q};

  // cell chain control
  assign ctl.op   = commit ? op : OP_HOLD;
  assign ctl.pool = pool_cfg_q;
  assign ctl.slot = slot_q;

  assign scan_start.tok = (state_q == FSM_EXEC) & need_scan;
  assign scan_start.hit = 1'b0;

  assign push_ent.valid = 1'b1;
  assign push_ent.slot  = slot_q;

  // free stack: cell 0 is the top
  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    ent_t  lower;
    ent_t  upper;
    scan_t scan_in;

    if (k == 0) begin : g_top
      assign lower   = push_ent;
      assign scan_in = scan_start;
    end else begin : g_mid
      assign lower   = ent[k-1];
      assign scan_in = scan[k-1];
    end

    if (k == POOL_DEPTH - 1) begin : g_bot
      assign upper = '0;
    end else begin : g_up
      assign upper = ent[k+1];
    end

    bspool_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .idx_i   (SLOT_W'(k)),
      .lower_i (lower),
      .upper_i (upper),
      .scan_i  (scan_in),
      .ent_o   (ent[k]),
      .scan_o  (scan[k])
    );
  end

endmodule

[rtl/bspool_checker.sv]
// port-level checker for the slot pool, bound to the top level
`timescale 1ns / 1ps
`include "buffer_slot_pool_with_access_check_macros.svh"

module bspool_checker import bspool_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    outstanding;
  logic [11:0]         buf_low;
  logic [11:0]         byte_low;

  assign status      = m_axis_tdata_o[3:0];
  assign outstanding = m_axis_tdata_o[69:66];
  assign buf_low     = m_axis_tdata_o[18:7];
  assign byte_low    = m_axis_tdata_o[33:22];

  // a stalled response holds
  `BSPOOL_ASSERT_NEXT(a_resp_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "response changed while stalled")

  // status codes stop at device too small
  `BSPOOL_ASSERT_IMPL(a_status_range, m_axis_tvalid_o, status <= ST_TOO_SMALL, "status code out of range")

  // outstanding handles never exceed the pool depth
  `BSPOOL_ASSERT_IMPL(a_outstanding_max, m_axis_tvalid_o, outstanding <= CNT_W'(POOL_DEPTH), "outstanding above pool depth")

  // offsets are whole blocks
  `BSPOOL_ASSERT_IMPL(a_offset_align, m_axis_tvalid_o, buf_low == '0 && byte_low == '0, "offset not block aligned")

endmodule

bind buffer_slot_pool_with_access_check bspool_checker u_bspool_checker (.*);
